@@ rtl/xcrd_pkg.sv @@
// ----------------------------------------------------------------------------
// xcrd_pkg
// Shared constants and types of the XOR-checked response deframer.
// ----------------------------------------------------------------------------
package xcrd_pkg;

  // Widths of the byte stream, the length field and the result status
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned StatusW = 3;

  // Length values that do not fit in this many bits are flagged too long
  localparam int unsigned     LengthBits = 16;
  localparam logic [LenW:0]   LenLimit   = (LenW + 1)'((1 << LengthBits) - 1);

  // Frame headers as seen through the four-byte window, oldest byte on top
  localparam logic [4*ByteW-1:0] HeadA = 32'hEAFF_5AA5;
  localparam logic [4*ByteW-1:0] HeadB = 32'hFFEA_5AA5;
  localparam logic [ByteW-1:0]   HeadXor = 8'hEA ^ 8'hFF ^ 8'h5A ^ 8'hA5;

  // First body byte, or check byte of an empty body, that rejects a frame of the second header kind
  localparam logic [ByteW-1:0] RejectByte = 8'h84;

  // Reset value of the max_length register
  localparam logic [LenW-1:0] MaxLengthReset = 16'd121;

  // Status carried by every result word
  typedef enum logic [StatusW-1:0] {
    StBody   = 3'd0,
    StGood   = 3'd1,
    StBad    = 3'd2,
    StLong   = 3'd3,
    StReject = 3'd4
  } status_e;

endpackage

@@ rtl/xor_checked_response_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// xor_checked_response_deframer_unit
// Hunts a byte stream for a framed response, checks its XOR and emits the body.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | rx_byte_i
//  out     | source    | out_valid_o / out_stall_i | body_byte_o, body_index_o,
//          |           |                           | header_kind_o, frame_last_o,
//          |           |                           | frame_status_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_data_i (max_length)
//
//  One byte is taken every cycle while in_stall_o is low; its result word, if any, appears in the
//  output register on the following cycle.
//  The frame state and the output register are the only sequential stages.
//  in_stall_o is raised only while a result word waits and out_stall_i is high.
//  rst_ni clears the frame state to hunting and sets max_length to 121.
// ----------------------------------------------------------------------------
module xor_checked_response_deframer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [xcrd_pkg::ByteW-1:0]          rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [xcrd_pkg::ByteW-1:0]          body_byte_o,
  output logic [xcrd_pkg::LenW-1:0]           body_index_o,
  output logic                                header_kind_o,
  output logic                                frame_last_o,
  output xcrd_pkg::status_e                   frame_status_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [xcrd_pkg::LenW-1:0]           cfg_data_i
);
  import xcrd_pkg::*;

  typedef enum logic [4:0] {
    PhHunt  = 5'b00001,
    PhLenHi = 5'b00010,
    PhLenLo = 5'b00100,
    PhBody  = 5'b01000,
    PhCheck = 5'b10000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [4*ByteW-1:0]  window_q, window_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [LenW-1:0]     count_q, count_d;
  logic [ByteW-1:0]    xor_q, xor_d;
  logic                variant_q, variant_d;
  logic [LenW-1:0]     max_len_q;

  logic                in_take;
  logic                res_valid;
  logic [ByteW-1:0]    res_byte;
  logic [LenW-1:0]     res_index;
  logic                res_last;
  status_e             res_status;
  logic [LenW-1:0]     len_full;
  logic [LenW-1:0]     count_inc;
  logic [4*ByteW-1:0]  window_shift;

  logic                out_valid_q;
  logic [ByteW-1:0]    out_byte_q;
  logic [LenW-1:0]     out_index_q;
  logic                out_kind_q;
  logic                out_last_q;
  status_e             out_status_q;

  // Stall the input only while a waiting word is held back
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign len_full     = {len_q[LenW-1:ByteW], rx_byte_i};
  assign count_inc    = count_q + LenW'(1);
  assign window_shift = {window_q[3*ByteW-1:0], rx_byte_i};

  // Advance the frame state for one byte and form its result word
  always_comb begin
    phase_d    = phase_q;
    window_d   = window_q;
    len_d      = len_q;
    count_d    = count_q;
    xor_d      = xor_q;
    variant_d  = variant_q;
    res_valid  = 1'b0;
    res_byte   = '0;
    res_index  = '0;
    res_last   = 1'b0;
    res_status = StBody;
    case (phase_q)
      PhLenHi: begin
        len_d   = {rx_byte_i, {(LenW-ByteW){1'b0}}};
        xor_d   = xor_q ^ rx_byte_i;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        xor_d = xor_q ^ rx_byte_i;
        if ((len_full > max_len_q) || ({1'b0, len_full} > LenLimit)) begin
          res_valid  = 1'b1;
          res_index  = len_full;
          res_last   = 1'b1;
          res_status = StLong;
          phase_d    = PhHunt;
          window_d   = '0;
          len_d      = '0;
          count_d    = '0;
          xor_d      = '0;
        end else begin
          len_d   = len_full;
          count_d = '0;
          phase_d = (len_full == '0) ? PhCheck : PhBody;
        end
      end
      PhBody: begin
        res_valid = 1'b1;
        res_byte  = rx_byte_i;
        if ((count_q == '0) && variant_q && (rx_byte_i == RejectByte)) begin
          res_last   = 1'b1;
          res_status = StReject;
          phase_d    = PhHunt;
          window_d   = '0;
          len_d      = '0;
          count_d    = '0;
          xor_d      = '0;
        end else begin
          res_index = count_q;
          xor_d     = xor_q ^ rx_byte_i;
          count_d   = count_inc;
          if (count_inc == len_q) begin
            phase_d = PhCheck;
          end
        end
      end
      PhCheck: begin
        res_valid = 1'b1;
        res_byte  = rx_byte_i;
        res_last  = 1'b1;
        if ((len_q == '0) && variant_q && (rx_byte_i == RejectByte)) begin
          res_status = StReject;
        end else begin
          res_index  = len_q;
          res_status = (rx_byte_i == xor_q) ? StGood : StBad;
        end
        phase_d  = PhHunt;
        window_d = '0;
        len_d    = '0;
        count_d  = '0;
        xor_d    = '0;
      end
      default: begin
        window_d = window_shift;
        if ((window_shift == HeadA) || (window_shift == HeadB)) begin
          variant_d = (window_shift == HeadB);
          xor_d     = HeadXor;
          len_d     = '0;
          count_d   = '0;
          phase_d   = PhLenHi;
        end else begin
          phase_d = PhHunt;
        end
      end
    endcase
  end

  // Hold the frame state, advance it on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      window_q  <= '0;
      len_q     <= '0;
      count_q   <= '0;
      xor_q     <= '0;
      variant_q <= 1'b0;
    end else if (in_take) begin
      phase_q   <= phase_d;
      window_q  <= window_d;
      len_q     <= len_d;
      count_q   <= count_d;
      xor_q     <= xor_d;
      variant_q <= variant_d;
    end
  end

  // Write the length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLengthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Output register: load a new word, drop the old one once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && res_valid) begin
      out_byte_q   <= res_byte;
      out_index_q  <= res_index;
      out_kind_q   <= variant_q;
      out_last_q   <= res_last;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign body_byte_o    = out_byte_q;
  assign body_index_o   = out_index_q;
  assign header_kind_o  = out_kind_q;
  assign frame_last_o   = out_last_q;
  assign frame_status_o = out_status_q;

endmodule

@@ rtl/xcrd_checker.sv @@
// ----------------------------------------------------------------------------
// xcrd_checker
// Port-level checks on the deframer, bound to its top level.
// ----------------------------------------------------------------------------
module xcrd_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_stall_o,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic [xcrd_pkg::ByteW-1:0]  body_byte_o,
  input  logic [xcrd_pkg::LenW-1:0]   body_index_o,
  input  xcrd_pkg::status_e           frame_status_o
);
  import xcrd_pkg::*;

  // Keep a stalled word valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled output word dropped");

  // Keep a stalled word unchanged
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(body_byte_o) && $stable(body_index_o))
    else $error("stalled output word changed");

  // Stall the input only behind a waiting word
  a_in_stall_cause: assert property (@(posedge clk_i)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting output word");

  // Show no word while in reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output word valid during reset");

  // Reject words carry the reject byte at index zero
  a_reject_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == StReject) |->
      (body_byte_o == RejectByte) && (body_index_o == '0))
    else $error("reject word with wrong byte or index");

endmodule

bind xor_checked_response_deframer_unit xcrd_checker u_xcrd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .body_byte_o    (body_byte_o),
  .body_index_o   (body_index_o),
  .frame_status_o (frame_status_o)
);

@@ verif/xcrd_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// xcrd_tb_pkg
// Frame tracker and result scoreboard for the response deframer testbench.
// Mirrors the hunt, length, body and check phases byte by byte and queues
// the result word that each received byte should produce.
// ----------------------------------------------------------------------------
package xcrd_tb_pkg;

  import xcrd_pkg::*;

  // Phases of a frame as the tracker follows them
  typedef enum logic [2:0] {
    PhHunt,
    PhLenHi,
    PhLenLo,
    PhBody,
    PhCheck
  } frame_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  index;
    logic             kind;
    logic             last;
    status_e          status;
  } result_word_t;

  class response_frame_scoreboard;

    logic [LenW-1:0]    max_length;
    logic [4*ByteW-1:0] window;
    frame_phase_e       phase;
    logic [LenW-1:0]    frame_len;
    logic [LenW-1:0]    body_count;
    logic [ByteW-1:0]   xor_acc;
    logic               kind;
    result_word_t       expected_words[$];
    int unsigned        mismatches;

    function new();
      max_length = MaxLengthReset;
      kind       = 1'b0;
      mismatches = 0;
      restart_hunt();
    endfunction

    // Clear the frame and go back to hunting; the header kind is kept
    function void restart_hunt();
      phase      = PhHunt;
      window     = '0;
      frame_len  = '0;
      body_count = '0;
      xor_acc    = '0;
    endfunction

    function void set_max_length(logic [LenW-1:0] value);
      max_length = value;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void queue_word(logic [ByteW-1:0] data, logic [LenW-1:0] index,
                             logic last, status_e status);
      result_word_t w;
      w.data   = data;
      w.index  = index;
      w.kind   = kind;
      w.last   = last;
      w.status = status;
      expected_words.push_back(w);
    endfunction

    // Advance the tracker by one accepted byte
    function void note_rx_byte(logic [ByteW-1:0] b);
      case (phase)
        PhLenHi: begin
          frame_len = {b, 8'h00};
          xor_acc   = xor_acc ^ b;
          phase     = PhLenLo;
        end
        PhLenLo: begin
          frame_len[7:0] = b;
          xor_acc        = xor_acc ^ b;
          if (frame_len > max_length || {1'b0, frame_len} > LenLimit) begin
            queue_word('0, frame_len, 1'b1, StLong);
            restart_hunt();
          end else begin
            body_count = '0;
            phase      = (frame_len == '0) ? PhCheck : PhBody;
          end
        end
        PhBody: begin
          // A second-kind frame opening its body with the reject byte is dropped
          if (body_count == '0 && kind && b == RejectByte) begin
            queue_word(b, '0, 1'b1, StReject);
            restart_hunt();
          end else begin
            queue_word(b, body_count, 1'b0, StBody);
            xor_acc    = xor_acc ^ b;
            body_count = body_count + 1'b1;
            if (body_count == frame_len) phase = PhCheck;
          end
        end
        PhCheck: begin
          if (frame_len == '0 && kind && b == RejectByte) begin
            queue_word(b, '0, 1'b1, StReject);
          end else begin
            queue_word(b, frame_len, 1'b1, (b == xor_acc) ? StGood : StBad);
          end
          restart_hunt();
        end
        default: begin
          // Slide the window and look for either header
          window = {window[3*ByteW-1:0], b};
          if (window == HeadA || window == HeadB) begin
            kind       = (window == HeadB);
            xor_acc    = HeadXor;
            frame_len  = '0;
            body_count = '0;
            phase      = PhLenHi;
          end else begin
            phase = PhHunt;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [LenW-1:0] want,
                                logic [LenW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Match one delivered word against the oldest one outstanding
    function void check_result_word(logic [ByteW-1:0] data, logic [LenW-1:0] index,
                                    logic hkind, logic last, status_e status);
      result_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: body_byte %0h body_index %0d status %0d",
               data, index, status);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("body_byte", LenW'(want.data), LenW'(data));
      compare_field("body_index", want.index, index);
      compare_field("header_kind", LenW'(want.kind), LenW'(hkind));
      compare_field("frame_last", LenW'(want.last), LenW'(last));
      compare_field("frame_status", LenW'(want.status), LenW'(status));
    endfunction

  endclass

endpackage

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives framed and noisy byte streams into the response deframer under
// random input gaps and output stalls, steps max_length through several
// settings including both extremes, and checks every result word in order.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import xcrd_pkg::*;
  import xcrd_tb_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [ByteW-1:0] rx_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [ByteW-1:0] body_byte_o;
  logic [LenW-1:0]  body_index_o;
  logic             header_kind_o;
  logic             frame_last_o;
  status_e          frame_status_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [LenW-1:0]  cfg_data_i;

  response_frame_scoreboard frames = new();

  logic [LenW-1:0] max_len_setting;
  bit              calm_input;
  int unsigned     bytes_sent;

  xor_checked_response_deframer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .body_byte_o    (body_byte_o),
    .body_index_o   (body_index_o),
    .header_kind_o  (header_kind_o),
    .frame_last_o   (frame_last_o),
    .frame_status_o (frame_status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  // Check every word that leaves the block
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      frames.check_result_word(body_byte_o, body_index_o, header_kind_o,
                               frame_last_o, frame_status_o);
    end
  end

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold off the output: quiet stretches, short stalls, the odd long one
  initial begin
    int unsigned run;
    out_stall_i <= 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 12);
      repeat (run + 1) @(posedge clk_i);
      out_stall_i <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 3))
        @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Offer one byte and hold it until taken, then maybe idle
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    frames.note_rx_byte(b);
    bytes_sent++;
    gap = calm_input ? 0 : gap_length();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= ByteW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every outstanding result word
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frames.pending() != 0);
  endtask

  task automatic write_max_length(input logic [LenW-1:0] value);
    drain_results();
    // allow a byte with no result to clear the pipeline
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    frames.set_max_length(value);
    max_len_setting = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Send header, length, body and check byte; stop early where the block will
  task automatic send_frame(input bit kind, input logic [LenW-1:0] len,
                            input bit reject, input bit good_check);
    logic [4*ByteW-1:0] head;
    logic [ByteW-1:0]   x;
    logic [ByteW-1:0]   b;
    int unsigned        i;
    head = kind ? HeadB : HeadA;
    x    = HeadXor;
    for (i = 0; i < 4; i++) send_byte(head[4*ByteW-1-8*i -: 8]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    x = x ^ len[15:8] ^ len[7:0];
    if (len > max_len_setting) return;
    for (i = 0; i < len; i++) begin
      b = ByteW'($urandom);
      if (i == 0 && reject) b = RejectByte;
      send_byte(b);
      x = x ^ b;
      if (i == 0 && kind && b == RejectByte) return;
    end
    if (len == 0 && reject) b = RejectByte;
    else b = good_check ? x : ByteW'($urandom);
    send_byte(b);
  endtask

  // Start of a header that breaks off into a random byte
  task automatic send_broken_header(input bit kind);
    logic [4*ByteW-1:0] head;
    int unsigned        n;
    head = kind ? HeadB : HeadA;
    n    = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) send_byte(head[4*ByteW-1-8*i -: 8]);
    send_byte(ByteW'($urandom));
  endtask

  // Mostly short bodies, with the limit, one past it and far past it mixed in
  function automatic logic [LenW-1:0] pick_length();
    logic [LenW-1:0] m;
    int unsigned     r;
    m = max_len_setting;
    r = $urandom_range(0, 99);
    if (r < 65) return LenW'($urandom_range(0, (m < 8) ? m : 8));
    if (r < 78) return (m <= 200) ? m : LenW'($urandom_range(9, 40));
    if (m == 16'hFFFF) return LenW'($urandom_range(0, 8));
    if (r < 90) return m + 1'b1;
    return LenW'($urandom_range(m + 1, 65535));
  endfunction

  task automatic random_phase(input int unsigned budget);
    int unsigned stop;
    int unsigned n;
    bit          kind;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      calm_input = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          n = $urandom_range(1, 4);
          repeat (n) send_byte(ByteW'($urandom));
        end
        3: send_broken_header(1'($urandom_range(0, 1)));
        4: drain_results();
        default: ;
      endcase
      kind = 1'($urandom_range(0, 1));
      send_frame(kind, pick_length(),
                 kind ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 19) == 0),
                 $urandom_range(0, 9) < 7);
    end
  endtask

  initial begin
    in_valid_i      <= 1'b0;
    rx_byte_i       <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    max_len_setting  = MaxLengthReset;
    calm_input       = 1'b0;
    bytes_sent       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Good check, reject on check byte, reject on first body word, too long
    send_frame(1'b1, 16'd1, 1'b0, 1'b1);
    send_frame(1'b1, 16'd0, 1'b1, 1'b1);
    send_frame(1'b1, 16'd1, 1'b1, 1'b1);
    send_frame(1'b0, 16'hFFFF, 1'b0, 1'b1);

    random_phase(100);
    write_max_length(16'd0);
    random_phase(90);
    write_max_length(16'hFFFF);
    random_phase(110);
    write_max_length(16'd3);
    random_phase(100);
    write_max_length(16'd200);
    random_phase(120);
    write_max_length(LenW'($urandom_range(1, 65534)));
    random_phase(100);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (frames.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
